/* rtl/core/blbs_pkg.sv */
package blbs_pkg;

  // lane geometry and queue sizing
  localparam int STEPS       = 13;
  localparam int QUEUE_DEPTH = 256;  // power of two, at least 4
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;
  localparam int BANK_DEPTH  = QUEUE_DEPTH / 2;
  localparam int BANK_W      = QPTR_W - 1;
  localparam int RIDER_W     = $clog2(STEPS + 1);

  // field widths
  localparam int STAMP_W = 16;
  localparam int CAP_W   = 9;
  localparam int BLIM_W  = 4;
  localparam int THR_W   = 8;
  localparam int CFG_W   = 9;

  // configuration register indexes
  localparam logic [1:0] CFG_CAPACITY = 2'd0;
  localparam logic [1:0] CFG_BATCH    = 2'd1;
  localparam logic [1:0] CFG_THRESH   = 2'd2;

  // reset values of the configuration registers
  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(200);
  localparam logic [BLIM_W-1:0] BLIM_RESET = BLIM_W'(2);
  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(6);

  // lane direction codes
  localparam logic [1:0] DIR_IDLE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  localparam logic [BLIM_W-1:0] BATCH_MAX = '1;

  typedef logic [STAMP_W-1:0] stamp_t;

  // one step of the lane
  typedef struct packed {
    logic   occ;
    stamp_t stamp;
  } step_t;

  // control shared by every cell
  typedef struct packed {
    logic shift;
    logic up;
  } cell_ctrl_t;

  typedef struct packed {
    logic [1:0] arrivals;
    logic       first_down;
    logic       second_down;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        lane_dir;
    logic              finished;
    logic [15:0]       turnaround;
    logic [8:0]        up_waiting;
    logic [8:0]        down_waiting;
    logic [3:0]        riders;
    logic [8:0]        population;
    logic [1:0]        refused;
    logic [3:0]        batches;
  } out_word_t;

endpackage

/* rtl/core/blbs_cell.sv */
module blbs_cell import blbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  step_t      lo_i,
  input  step_t      hi_i,
  output step_t      step_o
);

  logic   occ_q;
  stamp_t stamp_q;
  step_t  src;

  // neighbour that feeds this step in the current direction
  assign src = ctrl_i.up ? lo_i : hi_i;

  // occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      occ_q <= src.occ;
    end
  end

  // arrival stamp of the rider on this step
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      stamp_q <= src.stamp;
    end
  end

  assign step_o = '{occ: occ_q, stamp: stamp_q};

endmodule

/* rtl/core/blbs_fifo.sv */
module blbs_fifo import blbs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        push_n_i,
  input  stamp_t            push_data_i,
  input  logic              pop_i,
  output logic [QCNT_W-1:0] count_o,
  output stamp_t            pop_data_o
);

  // two interleaved banks so that two words can be written in one cycle
  stamp_t mem0 [BANK_DEPTH];
  stamp_t mem1 [BANK_DEPTH];

  logic [QPTR_W-1:0] rd_q, rd_d, wr_q, wr_d, wr_nx;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  stamp_t            rdata0_q, rdata1_q;
  logic              sel_q;
  logic              we0, we1;
  logic [BANK_W-1:0] wa0, wa1;

  assign wr_nx = wr_q + QPTR_W'(1);

  // bank write enables and addresses
  always_comb begin
    we0 = 1'b0;
    we1 = 1'b0;
    wa0 = wr_q[QPTR_W-1:1];
    wa1 = wr_q[QPTR_W-1:1];
    if (push_n_i != 2'd0) begin
      if (wr_q[0]) begin
        we1 = 1'b1;
      end else begin
        we0 = 1'b1;
      end
    end
    if (push_n_i == 2'd2) begin
      if (wr_q[0]) begin
        we0 = 1'b1;
        wa0 = wr_nx[QPTR_W-1:1];
      end else begin
        we1 = 1'b1;
        wa1 = wr_nx[QPTR_W-1:1];
      end
    end
  end

  // pointers and fill count
  always_comb begin
    rd_d  = rd_q + QPTR_W'(pop_i);
    wr_d  = wr_q + QPTR_W'(push_n_i);
    cnt_d = cnt_q - QCNT_W'(pop_i) + QCNT_W'(push_n_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
      sel_q <= 1'b0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
      if (pop_i) begin
        sel_q <= rd_q[0];
      end
    end
  end

  // bank 0, read before write
  always_ff @(posedge clk_i) begin
    if (pop_i && !rd_q[0]) begin
      rdata0_q <= mem0[rd_q[QPTR_W-1:1]];
    end
    if (we0) begin
      mem0[wa0] <= push_data_i;
    end
  end

  // bank 1, read before write
  always_ff @(posedge clk_i) begin
    if (pop_i && rd_q[0]) begin
      rdata1_q <= mem1[rd_q[QPTR_W-1:1]];
    end
    if (we1) begin
      mem1[wa1] <= push_data_i;
    end
  end

  assign count_o    = cnt_q;
  assign pop_data_o = sel_q ? rdata1_q : rdata0_q;

endmodule

/* rtl/core/bidirectional_lane_batch_scheduler.sv */
// Bidirectional lane batch scheduler: one input word is one tick.
// Input channel (in_valid_i/in_ready_o/in_word_i): arrivals this tick (0..2,
// three counts as two) and the queue of each arrival. Output channel
// (out_valid_o/out_ready_i/out_word_o): one result word per tick with the
// lane direction, the rider leaving the exit and its turnaround, queue
// lengths, riders on the lane, population, refused arrivals and batch count.
// Configuration (cfg_we_i/cfg_idx_i/cfg_data_i): capacity, batch limit and
// imbalance threshold, which the user writes only while the block is idle;
// the block does not enforce it. Results are registered in the result queue.
// Throughput: one tick per cycle while in_ready_o is high; STEPS cells
// shift once per active tick; each queue is a two-bank memory taking two
// writes and one read a cycle. A popped stamp lands in a read register and
// joins the chain on the next tick, when its rider leaves the entrance step.
// A two-word result queue sits on the output: the input is still taken while
// one result waits, and in_ready_o drops once two results are held.
// Reset empties the lane, queues and result queue, sets the lane idle, clears
// the tick counter and loads the default configuration.
module bidirectional_lane_batch_scheduler import blbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_word_t   in_word_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_word_t  out_word_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  // configuration
  logic [CAP_W-1:0]  cap_q;
  logic [BLIM_W-1:0] blim_q;
  logic [THR_W-1:0]  thr_q;

  // scheduler state
  logic [1:0]         dir_q, dir_d;
  logic [BLIM_W-1:0]  batch_q, batch_d;
  logic [RIDER_W-1:0] rider_q, rider_d;
  logic [QCNT_W-1:0]  head_q, head_d;
  stamp_t             now_q;

  // lane chain
  cell_ctrl_t ctrl;
  step_t      steps [STEPS];
  step_t      lo_in [STEPS];
  step_t      hi_in [STEPS];
  logic [STEPS-1:0] occ_vec;

  // queues
  logic [QCNT_W-1:0] up_cnt, dn_cnt;
  stamp_t            up_rd, dn_rd;
  logic [1:0]        up_push, dn_push;
  logic              pop_up, pop_dn;

  // tick logic
  logic       acc;
  logic       active, up, finished, pop;
  stamp_t     exit_stamp, turn;
  logic [QCNT_W-1:0] up_c1, dn_c1, up_c2, dn_c2, mine, other, qc;
  logic [QCNT_W-1:0] head1;
  logic [BLIM_W-1:0] b1;
  logic [1:0]        n_arr, refused;
  logic              dn_a, ok;
  out_word_t         res;

  // result queue
  out_word_t  slot_q [2];
  out_word_t  slot_d [2];
  logic [1:0] ocnt_q, ocnt_d, ocnt_mid;
  logic       opop;

  assign acc = in_valid_i && in_ready_o;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CAP_RESET;
      blim_q <= BLIM_RESET;
      thr_q  <= THR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CAPACITY: cap_q  <= cfg_data_i[CAP_W-1:0];
        CFG_BATCH:    blim_q <= cfg_data_i[BLIM_W-1:0];
        CFG_THRESH:   thr_q  <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // exit and entrance of the lane
  assign active     = (dir_q == DIR_UP) || (dir_q == DIR_DOWN);
  assign up         = (dir_q == DIR_UP);
  assign exit_stamp = up ? steps[STEPS-1].stamp : steps[0].stamp;
  assign finished   = active && (up ? steps[STEPS-1].occ : steps[0].occ);
  assign turn       = finished ? (now_q - exit_stamp) : '0;
  assign pop        = active && (up ? (up_cnt != '0) : (dn_cnt != '0));
  assign pop_up     = acc && pop && up;
  assign pop_dn     = acc && pop && !up;

  // direction, batches and arrivals of one tick
  always_comb begin
    up_c1   = up_cnt - QCNT_W'(pop && up);
    dn_c1   = dn_cnt - QCNT_W'(pop && !up);
    rider_d = rider_q - RIDER_W'(finished) + RIDER_W'(pop);
    head1   = head_q - QCNT_W'(finished);
    dir_d   = dir_q;
    batch_d = batch_q;
    b1      = (batch_q == BATCH_MAX) ? BATCH_MAX : batch_q + BLIM_W'(1);
    mine    = up ? up_c1 : dn_c1;
    other   = up ? dn_c1 : up_c1;

    // an emptied lane ends a batch
    if (active && rider_d == '0) begin
      batch_d = b1;
      if (up_c1 == '0 && dn_c1 == '0) begin
        dir_d   = DIR_IDLE;
        batch_d = '0;
      end else if ((b1 >= blim_q && other != '0) ||
                   (other >= mine && (other - mine) >= QCNT_W'(thr_q))) begin
        dir_d   = up ? DIR_DOWN : DIR_UP;
        batch_d = '0;
      end
    end

    // an idle lane takes the longer queue
    if (dir_d == DIR_IDLE) begin
      if (up_c1 != '0 && up_c1 >= dn_c1) begin
        dir_d = DIR_UP;
      end else if (dn_c1 != '0) begin
        dir_d = DIR_DOWN;
      end
    end

    // arrivals, first then second
    n_arr   = (in_word_i.arrivals == 2'd3) ? 2'd2 : in_word_i.arrivals;
    up_c2   = up_c1;
    dn_c2   = dn_c1;
    head_d  = head1;
    refused = '0;
    up_push = '0;
    dn_push = '0;
    for (int i = 0; i < 2; i++) begin
      dn_a = (i == 0) ? in_word_i.first_down : in_word_i.second_down;
      qc   = dn_a ? dn_c2 : up_c2;
      ok   = (head_d < QCNT_W'(cap_q)) && (qc < QCNT_W'(QUEUE_DEPTH));
      if (n_arr > 2'(i)) begin
        if (ok) begin
          head_d = head_d + QCNT_W'(1);
          if (dn_a) begin
            dn_c2   = dn_c2 + QCNT_W'(1);
            dn_push = dn_push + 2'd1;
          end else begin
            up_c2   = up_c2 + QCNT_W'(1);
            up_push = up_push + 2'd1;
          end
        end else begin
          refused = refused + 2'd1;
        end
      end
    end
    if (!acc) begin
      up_push = '0;
      dn_push = '0;
    end

    res.lane_dir     = dir_d;
    res.finished     = finished;
    res.turnaround   = turn;
    res.up_waiting   = 9'(up_c2);
    res.down_waiting = 9'(dn_c2);
    res.riders       = 4'(rider_d);
    res.population   = 9'(head_d);
    res.refused      = refused;
    res.batches      = batch_d;
  end

  // scheduler registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= DIR_IDLE;
      batch_q <= '0;
      rider_q <= '0;
      head_q  <= '0;
      now_q   <= '0;
    end else if (acc) begin
      dir_q   <= dir_d;
      batch_q <= batch_d;
      rider_q <= rider_d;
      head_q  <= head_d;
      now_q   <= now_q + STAMP_W'(1);
    end
  end

  // waiting queues
  blbs_fifo u_up_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (up_push),
    .push_data_i (now_q),
    .pop_i       (pop_up),
    .count_o     (up_cnt),
    .pop_data_o  (up_rd)
  );

  blbs_fifo u_dn_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (dn_push),
    .push_data_i (now_q),
    .pop_i       (pop_dn),
    .count_o     (dn_cnt),
    .pop_data_o  (dn_rd)
  );

  // row of lane cells; the step next to the entrance takes the popped stamp
  assign ctrl = '{shift: acc && active, up: up};

  for (genvar g = 0; g < STEPS; g++) begin : g_cell
    if (g == 0) begin : g_lo_ent
      assign lo_in[g] = '{occ: pop, stamp: up_rd};
    end else if (g == 1) begin : g_lo_first
      assign lo_in[g] = '{occ: steps[g-1].occ, stamp: up_rd};
    end else begin : g_lo_mid
      assign lo_in[g] = steps[g-1];
    end

    if (g == STEPS - 1) begin : g_hi_ent
      assign hi_in[g] = '{occ: pop, stamp: dn_rd};
    end else if (g == STEPS - 2) begin : g_hi_first
      assign hi_in[g] = '{occ: steps[g+1].occ, stamp: dn_rd};
    end else begin : g_hi_mid
      assign hi_in[g] = steps[g+1];
    end

    blbs_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .lo_i   (lo_in[g]),
      .hi_i   (hi_in[g]),
      .step_o (steps[g])
    );

    assign occ_vec[g] = steps[g].occ;
  end

  // two-word result queue
  assign opop       = (ocnt_q != 2'd0) && out_ready_i;
  assign in_ready_o = (ocnt_q != 2'd2);

  always_comb begin
    slot_d   = slot_q;
    ocnt_mid = ocnt_q - 2'(opop);
    if (opop) begin
      slot_d[0] = slot_q[1];
    end
    if (acc) begin
      slot_d[ocnt_mid[0]] = res;
    end
    ocnt_d = ocnt_mid + 2'(acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q <= '0;
    end else begin
      ocnt_q <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign out_valid_o = (ocnt_q != 2'd0);
  assign out_word_o  = slot_q[0];

  // rider count follows the occupied cells
  a_riders: assert property (@(posedge clk_i) disable iff (!rst_ni)
    RIDER_W'($countones(occ_vec)) == rider_q)
    else $error("rider count differs from occupied steps");

  // population is the queues plus the lane
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q == up_cnt + dn_cnt + QCNT_W'(rider_q))
    else $error("population out of step with queues and lane");

  // an idle lane holds no rider
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dir_q == DIR_IDLE) |-> (rider_q == '0))
    else $error("rider on an idle lane");

  // direction changes only on an empty lane
  a_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active && acc && rider_d != '0) |=> (dir_q == $past(dir_q)))
    else $error("direction changed with riders on the lane");

  // result queue never overfills
  a_oq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ocnt_q == 2'd2) |-> !acc)
    else $error("word accepted into a full result queue");

endmodule
